// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// generic clocked assertion with explicit clock and active-low reset
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion on the default clock and reset of this project
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg)
`define ASSERT_STD(label, prop, msg)
`endif

`endif

// ===== design/fdcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdcr_pkg
// shared types, constants and the fan curve for the duty ramp controller
// ----------------------------------------------------------------------------
`default_nettype none

package fdcr_pkg;

  // widths
  localparam int unsigned COUNT_BITS = 10;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned TAB_DEPTH  = 1 << PCT_W;

  // limits and reset values
  localparam logic [PCT_W-1:0]  PCT_MAX        = 7'd100;
  localparam logic [STEP_W-1:0] RAMP_UP_RESET  = 6'd2;
  localparam logic [STEP_W-1:0] RAMP_DN_RESET  = 6'd3;

  // word command codes
  typedef enum logic [0:0] {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_UP   = 2'd0,
    REG_RAMP_DOWN = 2'd1
  } cfg_reg_e;

  // curve lookup result
  typedef struct packed {
    logic [PCT_W-1:0] target;
    logic             speed_zero;
  } curve_t;

  // per-word result without the count
  typedef struct packed {
    logic [PCT_W-1:0] duty;
    logic [PCT_W-1:0] target;
    logic             written;
  } res_t;

  // three-segment fan curve, evaluated at elaboration to build a table
  function automatic logic [PCT_W-1:0] map_curve(input int unsigned s);
    int unsigned m;
    begin
      if (s == 0) begin
        m = 0;
      end else if (s <= 30) begin
        m = 25 + s;
      end else if (s <= 70) begin
        m = 55 + ((s - 30) * 25) / 40;
      end else begin
        m = 80 + ((s - 70) * 20) / 30;
      end
      if (m > 100) begin
        m = 100;
      end
      return m[PCT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/fdcr_curve.sv =====
// ----------------------------------------------------------------------------
// fdcr_curve
// clamps the logical speed and maps it through the fan curve table
// ----------------------------------------------------------------------------
`default_nettype none

module fdcr_curve (
  input  wire logic [fdcr_pkg::SPEED_W-1:0] speed_i,
  output fdcr_pkg::curve_t                  curve_o
);

  logic [fdcr_pkg::PCT_W-1:0] curve_tab [fdcr_pkg::TAB_DEPTH];
  logic [fdcr_pkg::PCT_W-1:0] spd_clamped;

  // constant curve table, one entry per 7-bit index, addressed by the clamped speed
  for (genvar g = 0; g < fdcr_pkg::TAB_DEPTH; g++) begin : g_tab
    assign curve_tab[g] = fdcr_pkg::map_curve(g);
  end

  // clamp speed to 100
  always_comb begin
    if (speed_i > {1'b0, fdcr_pkg::PCT_MAX}) begin
      spd_clamped = fdcr_pkg::PCT_MAX;
    end else begin
      spd_clamped = speed_i[fdcr_pkg::PCT_W-1:0];
    end
  end

  assign curve_o.target     = curve_tab[spd_clamped];
  assign curve_o.speed_zero = (spd_clamped == '0);

endmodule

`default_nettype wire

// ===== design/fdcr_ramp.sv =====
// ----------------------------------------------------------------------------
// fdcr_ramp
// duty and target state, set and tick handling, compare count lookup
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fdcr_ramp #(
  parameter int unsigned CountBits = fdcr_pkg::COUNT_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_en_i,
  input  wire fdcr_pkg::cmd_e              cmd_i,
  input  wire fdcr_pkg::curve_t            curve_i,
  input  wire logic [fdcr_pkg::STEP_W-1:0] up_step_i,
  input  wire logic [fdcr_pkg::STEP_W-1:0] down_step_i,
  output fdcr_pkg::res_t                   res_o,
  output logic [CountBits-1:0]             count_o
);

  localparam int unsigned Full = (1 << CountBits) - 1;

  logic [fdcr_pkg::PCT_W-1:0] cur_q, cur_d;
  logic [fdcr_pkg::PCT_W-1:0] tgt_q, tgt_d;
  logic                       wrote;
  logic [fdcr_pkg::PCT_W:0]   up_sum;
  logic [fdcr_pkg::PCT_W-1:0] dn_diff;
  logic [CountBits-1:0]       count_tab [fdcr_pkg::TAB_DEPTH];

  // percent to compare count table, built at elaboration
  for (genvar g = 0; g < fdcr_pkg::TAB_DEPTH; g++) begin : g_cnt
    localparam int unsigned Cnt = (g * Full) / 100;
    assign count_tab[g] = Cnt[CountBits-1:0];
  end

  // next duty and target for the word in flight
  always_comb begin
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    wrote   = 1'b0;
    up_sum  = {1'b0, cur_q} + {2'b00, up_step_i};
    dn_diff = (cur_q >= {1'b0, down_step_i}) ? (cur_q - {1'b0, down_step_i}) : '0;
    case (cmd_i)
      fdcr_pkg::CMD_SET: begin
        tgt_d = curve_i.target;
        if (curve_i.speed_zero && (cur_q != '0)) begin
          cur_d = '0;
          wrote = 1'b1;
        end else if (!curve_i.speed_zero && (cur_q == '0)) begin
          cur_d = curve_i.target;
          wrote = 1'b1;
        end
      end
      fdcr_pkg::CMD_TICK: begin
        if (cur_q != tgt_q) begin
          wrote = 1'b1;
          if (cur_q < tgt_q) begin
            cur_d = (up_sum > {1'b0, tgt_q}) ? tgt_q : up_sum[fdcr_pkg::PCT_W-1:0];
          end else begin
            cur_d = (dn_diff < tgt_q) ? tgt_q : dn_diff;
          end
        end
      end
      default: begin
        wrote = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      tgt_q <= '0;
    end else if (step_en_i) begin
      cur_q <= cur_d;
      tgt_q <= tgt_d;
    end
  end

  assign res_o.duty    = cur_d;
  assign res_o.target  = tgt_d;
  assign res_o.written = wrote;
  assign count_o       = count_tab[cur_d];

  // checks
  `ASSERT_STD(a_duty_range, cur_q <= fdcr_pkg::PCT_MAX, "duty above 100 percent")
  `ASSERT_STD(a_tgt_range, tgt_q <= fdcr_pkg::PCT_MAX, "target above 100 percent")
  `ASSERT_STD(a_hold_idle, !step_en_i |=> $stable(cur_q) && $stable(tgt_q), "state moved idle")
  `ASSERT_STD(a_tick_at_tgt,
              step_en_i && (cmd_i == fdcr_pkg::CMD_TICK) && (cur_q == tgt_q) |-> !wrote,
              "tick at target wrote count")

endmodule

`default_nettype wire

// ===== design/fan_duty_curve_ramp.sv =====
// ----------------------------------------------------------------------------
// fan_duty_curve_ramp
// fan pwm duty controller: fan curve mapping and slew-rate limited ramp
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  in       | in_valid_i, in_ready_o, command_i,       | word in
//           | speed_i                                  |
//  out      | out_valid_o, out_ready_i, duty_percent_o,| word out
//           | duty_count_o, target_percent_o,          |
//           | count_written_o                          |
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i          | register write
//
//  one word per cycle while out is not stalled; a result is presented on out
//  once its word has moved from the input register into the result register.
//  state updates as a word moves from the input to the result register.
//  a stall on out holds the result and back-pressures in only once the
//  input register is also occupied.
//  reset clears duty, target, valid flags and loads ramp steps 2 up, 3 down.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fan_duty_curve_ramp #(
  parameter int unsigned CountBits = fdcr_pkg::COUNT_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           command_i,
  input  wire logic [fdcr_pkg::SPEED_W-1:0]   speed_i,
  // result words
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [fdcr_pkg::PCT_W-1:0]          duty_percent_o,
  output logic [CountBits-1:0]                duty_count_o,
  output logic [fdcr_pkg::PCT_W-1:0]          target_percent_o,
  output logic                                count_written_o,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [fdcr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fdcr_pkg::STEP_W-1:0]    cfg_data_i
);

  logic                         in_vld_q;
  fdcr_pkg::cmd_e               in_cmd_q;
  logic [fdcr_pkg::SPEED_W-1:0] in_speed_q;
  logic                         out_vld_q;
  fdcr_pkg::res_t               out_res_q;
  logic [CountBits-1:0]         out_cnt_q;
  logic [fdcr_pkg::STEP_W-1:0]  up_step_q;
  logic [fdcr_pkg::STEP_W-1:0]  down_step_q;
  logic                         out_adv;
  logic                         step_en;
  fdcr_pkg::curve_t             curve;
  fdcr_pkg::res_t               res;
  logic [CountBits-1:0]         cnt;

  // handshake
  assign out_adv    = !out_vld_q || out_ready_i;
  assign step_en    = in_vld_q && out_adv;
  assign in_ready_o = !in_vld_q || out_adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_step_q   <= fdcr_pkg::RAMP_UP_RESET;
      down_step_q <= fdcr_pkg::RAMP_DN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fdcr_pkg::REG_RAMP_UP:   up_step_q   <= cfg_data_i;
        fdcr_pkg::REG_RAMP_DOWN: down_step_q <= cfg_data_i;
        default: begin
          up_step_q <= up_step_q;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_cmd_q   <= fdcr_pkg::cmd_e'(command_i);
      in_speed_q <= speed_i;
    end
  end

  // curve lookup
  fdcr_curve u_curve (
    .speed_i (in_speed_q),
    .curve_o (curve)
  );

  // ramp state and count
  fdcr_ramp #(
    .CountBits (CountBits)
  ) u_ramp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .cmd_i       (in_cmd_q),
    .curve_i     (curve),
    .up_step_i   (up_step_q),
    .down_step_i (down_step_q),
    .res_o       (res),
    .count_o     (cnt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_res_q <= res;
      out_cnt_q <= cnt;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign duty_percent_o   = out_res_q.duty;
  assign target_percent_o = out_res_q.target;
  assign count_written_o  = out_res_q.written;
  assign duty_count_o     = out_cnt_q;

  // checks
  `ASSERT_STD(a_stall_full, !in_ready_o |-> in_vld_q && out_vld_q, "stall without full pipe")
  `ASSERT_STD(a_step_out, step_en |=> out_vld_q, "word lost between stages")

endmodule

`default_nettype wire
